// ===== src/kect_pkg.sv =====
// ----------------------------------------------------------------------------
// kect_pkg: shared types and constants for the keyed event counter table
// Holds table sizes, command and status codes, and the control/status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package kect_pkg;
	localparam int CallSlots = 16;
	localparam int RecordsPerCall = 32;
	localparam int NameBytes = 16;
	localparam int SlotW = $clog2(CallSlots);
	localparam int RecW = $clog2(RecordsPerCall);
	localparam int AddrW = SlotW + RecW;
	localparam logic [63:0] HighMask = (NameBytes - 8 >= 8) ? '1 :
		((64'd1 << (8 * (NameBytes - 8))) - 64'd1);

	localparam logic [1:0] CmdCount = 2'd0;
	localparam logic [1:0] CmdClear = 2'd1;
	localparam logic [1:0] CmdRead  = 2'd2;

	localparam logic [2:0] StCounted     = 3'd0;
	localparam logic [2:0] StRecordAdded = 3'd1;
	localparam logic [2:0] StCallAdded   = 3'd2;
	localparam logic [2:0] StIgnored     = 3'd3;
	localparam logic [2:0] StCleared     = 3'd4;
	localparam logic [2:0] StReadEmpty   = 3'd5;
	localparam logic [2:0] StReadOk      = 3'd6;

	// controller -> datapath
	typedef struct packed {
		logic latch;      // capture inputs
		logic clear;      // empty table
		logic slot_rst;   // reset slot counter
		logic slot_inc;
		logic rec_rst;
		logic rec_inc;
		logic rd_slot;    // issue memory read at slot/record counters
		logic rd_sel;     // issue memory read at selected record
		logic sel_slot;   // load slot counter from read slot select
		logic claim;      // claim ring slot
		logic put_rec;    // write new record
		logic bump;       // increment matched count
		logic load_max;   // reset max
		logic acc_max;    // fold read count into max
		logic div_start;
		logic div_step;
		logic save_sel;   // keep selected record data
		logic fin;        // present result
		logic [2:0] st;
	} kect_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] cmd;
		logic armed;
		logic slot_last;
		logic rec_last;
		logic slot_hit;   // current slot used and name matches
		logic rec_hit;    // current record valid and matches
		logic rec_valid;  // current record valid
		logic sel_ok;     // read selection in range and valid
		logic div_done;
	} kect_sts_t;
endpackage
`default_nettype wire

// ===== src/kect_ctrl.sv =====
// ----------------------------------------------------------------------------
// kect_ctrl: sequencer for the keyed event counter table
// Decodes clear, count and read; walks slots and records for events, scans a slot and divides for reads.
// ----------------------------------------------------------------------------
`default_nettype none
module kect_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	output kect_pkg::kect_cmd_t cmd,
	input  kect_pkg::kect_sts_t sts
);
	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_SRD, S_SCHK, S_RRD, S_RCHK, S_MRD, S_MCHK,
		S_SELRD, S_SELW, S_DIV, S_DONE
	} state_t;
	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.st = kect_pkg::StIgnored;
		cmd.latch = (state_q == S_IDLE) && start;
		unique case (state_q)
			S_IDLE: ;
			S_DEC: begin
				unique case (sts.cmd)
					kect_pkg::CmdClear: begin
						cmd.clear = 1'b1;
						cmd.fin = 1'b1;
						cmd.st = kect_pkg::StCleared;
					end
					kect_pkg::CmdCount: begin
						if (sts.armed) begin
							cmd.slot_rst = 1'b1;
						end else begin
							cmd.fin = 1'b1;
						end
					end
					kect_pkg::CmdRead: begin
						if (!sts.sel_ok) begin
							cmd.fin = 1'b1;
							cmd.st = kect_pkg::StReadEmpty;
						end else begin
							cmd.rec_rst = 1'b1;
							cmd.load_max = 1'b1;
							cmd.sel_slot = 1'b1;
						end
					end
					default: cmd.fin = 1'b1;
				endcase
			end
			S_SRD: cmd.rd_slot = 1'b1;
			S_SCHK: begin
				if (sts.slot_hit) begin
					cmd.rec_rst = 1'b1;
				end else if (sts.slot_last) begin
					cmd.claim = 1'b1;
					cmd.put_rec = 1'b1;
					cmd.fin = 1'b1;
					cmd.st = kect_pkg::StCallAdded;
				end else begin
					cmd.slot_inc = 1'b1;
				end
			end
			S_RRD: cmd.rd_slot = 1'b1;
			S_RCHK: begin
				if (sts.rec_hit) begin
					cmd.bump = 1'b1;
					cmd.fin = 1'b1;
					cmd.st = kect_pkg::StCounted;
				end else if (sts.rec_last) begin
					cmd.put_rec = 1'b1;
					cmd.fin = 1'b1;
					cmd.st = kect_pkg::StRecordAdded;
				end else begin
					cmd.rec_inc = 1'b1;
				end
			end
			S_MRD: cmd.rd_slot = 1'b1;
			S_MCHK: begin
				cmd.acc_max = 1'b1;
				if (!sts.rec_last) cmd.rec_inc = 1'b1;
			end
			S_SELRD: cmd.rd_sel = 1'b1;
			S_SELW: begin
				cmd.save_sel = 1'b1;
				cmd.div_start = 1'b1;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.fin = 1'b1;
					cmd.st = kect_pkg::StReadOk;
				end
			end
			S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_DEC;
					busy <= 1'b1;
				end
				S_DEC: begin
					if (cmd.fin) state_q <= S_DONE;
					else if (sts.cmd == kect_pkg::CmdCount) state_q <= S_SRD;
					else state_q <= S_MRD;
				end
				S_SRD: state_q <= S_SCHK;
				S_SCHK: begin
					if (sts.slot_hit) state_q <= S_RRD;
					else if (sts.slot_last) state_q <= S_DONE;
					else state_q <= S_SRD;
				end
				S_RRD: state_q <= S_RCHK;
				S_RCHK: begin
					if (cmd.fin) state_q <= S_DONE;
					else state_q <= S_RRD;
				end
				S_MRD: state_q <= S_MCHK;
				S_MCHK: state_q <= sts.rec_last ? S_SELRD : S_MRD;
				S_SELRD: state_q <= S_SELW;
				S_SELW: state_q <= S_DIV;
				S_DIV: if (sts.div_done) state_q <= S_DONE;
				S_DONE: begin
					state_q <= S_IDLE;
					busy <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/kect_dp.sv =====
// ----------------------------------------------------------------------------
// kect_dp: datapath of the keyed event counter table
// Slot and record memories, walk counters, max scan and a restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module kect_dp (
	input  wire logic clk,
	input  wire logic arst_n,
	input  kect_pkg::kect_cmd_t cmd,
	output kect_pkg::kect_sts_t sts,
	input  wire logic [1:0]  command,
	input  wire logic [63:0] call_name_low,
	input  wire logic [63:0] call_name_high,
	input  wire logic [63:0] program_name_low,
	input  wire logic [63:0] program_name_high,
	input  wire logic [31:0] user_id,
	input  wire logic [3:0]  slot_select,
	input  wire logic [4:0]  record_select,
	output logic        done,
	output logic [2:0]  status,
	output logic [63:0] out_call_low,
	output logic [63:0] out_call_high,
	output logic [63:0] out_program_low,
	output logic [63:0] out_program_high,
	output logic [31:0] out_user_id,
	output logic [31:0] event_count,
	output logic [3:0]  bar_ticks,
	output logic [3:0]  next_call_slot
);
	localparam int NS = kect_pkg::CallSlots;
	localparam int NR = kect_pkg::RecordsPerCall;
	localparam int SW = kect_pkg::SlotW;
	localparam int RW = kect_pkg::RecW;
	localparam int AW = kect_pkg::AddrW;

	// captured item
	logic [1:0]  cmd_q;
	logic [63:0] cl_q, ch_q, pl_q, ph_q;
	logic [31:0] uid_q;
	logic [3:0]  ssel_q;
	logic [4:0]  rsel_q;

	logic armed_q;
	logic [SW-1:0] ring_q;
	logic [NS-1:0] used_q;
	logic [NR-1:0] vmask_q [NS];
	logic [RW-1:0] rpos_q [NS];
	logic [63:0] sname_lo_q [NS];
	logic [63:0] sname_hi_q [NS];

	// record memory
	logic [63:0] mem_pl [1 << AW];
	logic [63:0] mem_ph [1 << AW];
	logic [31:0] mem_uid [1 << AW];
	logic [31:0] mem_cnt [1 << AW];
	logic [63:0] rd_pl_q, rd_ph_q;
	logic [31:0] rd_uid_q, rd_cnt_q;

	logic [SW-1:0] slot_q;
	logic [RW-1:0] rec_q;
	logic [31:0] max_q;

	// divider
	logic [35:0] num_q;
	logic [3:0]  quo_q;
	logic [35:0] rem_q;
	logic [5:0]  dstep_q;

	logic [63:0] sel_cl_q, sel_ch_q, sel_pl_q, sel_ph_q;
	logic [31:0] sel_uid_q, sel_cnt_q;

	logic [SW-1:0] ssel_n;
	logic [RW-1:0] rsel_n;
	logic sel_range;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [SW-1:0] wr_slot;
	logic [RW-1:0] wr_rec;
	logic [35:0] trial;

	assign ssel_n = ssel_q[SW-1:0];
	assign rsel_n = rsel_q[RW-1:0];
	assign sel_range = ({28'd0, ssel_q} < 32'(NS)) && ({27'd0, rsel_q} < 32'(NR));

	assign sts.cmd = cmd_q;
	assign sts.armed = armed_q;
	assign sts.slot_last = (slot_q == SW'(NS - 1));
	assign sts.rec_last = (rec_q == RW'(NR - 1));
	assign sts.slot_hit = used_q[slot_q] && (sname_lo_q[slot_q] == cl_q) &&
		(sname_hi_q[slot_q] == ch_q);
	assign sts.rec_valid = vmask_q[slot_q][rec_q];
	assign sts.rec_hit = sts.rec_valid && (rd_pl_q == pl_q) && (rd_ph_q == ph_q) &&
		(rd_uid_q == uid_q);
	assign sts.sel_ok = sel_range && used_q[ssel_n] && vmask_q[ssel_n][rsel_n];
	assign sts.div_done = (dstep_q == 6'd0);

	assign rd_addr = cmd.rd_sel ? {ssel_n, rsel_n} : {slot_q, rec_q};
	assign wr_slot = cmd.claim ? ring_q : slot_q;
	assign wr_rec = cmd.claim ? '0 : (cmd.bump ? rec_q : rpos_q[slot_q]);
	assign wr_addr = {wr_slot, wr_rec};
	assign trial = {rem_q[34:0], num_q[35]};

	always_ff @(posedge clk) begin
		if (cmd.rd_slot || cmd.rd_sel) begin
			rd_pl_q <= mem_pl[rd_addr];
			rd_ph_q <= mem_ph[rd_addr];
			rd_uid_q <= mem_uid[rd_addr];
			rd_cnt_q <= mem_cnt[rd_addr];
		end
		if (cmd.put_rec) begin
			mem_pl[wr_addr] <= pl_q;
			mem_ph[wr_addr] <= ph_q;
			mem_uid[wr_addr] <= uid_q;
			mem_cnt[wr_addr] <= 32'd1;
		end else if (cmd.bump && rd_cnt_q != 32'hFFFF_FFFF) begin
			mem_cnt[wr_addr] <= rd_cnt_q + 32'd1;
		end
		if (cmd.latch) begin
			cmd_q <= command;
			cl_q <= call_name_low;
			ch_q <= call_name_high & kect_pkg::HighMask;
			pl_q <= program_name_low;
			ph_q <= program_name_high & kect_pkg::HighMask;
			uid_q <= user_id;
			ssel_q <= slot_select;
			rsel_q <= record_select;
		end
		if (cmd.claim) begin
			sname_lo_q[ring_q] <= cl_q;
			sname_hi_q[ring_q] <= ch_q;
		end
		if (cmd.save_sel) begin
			sel_cl_q <= sname_lo_q[ssel_n];
			sel_ch_q <= sname_hi_q[ssel_n];
			sel_pl_q <= rd_pl_q;
			sel_ph_q <= rd_ph_q;
			sel_uid_q <= rd_uid_q;
			sel_cnt_q <= rd_cnt_q;
		end
		if (cmd.load_max) max_q <= '0;
		else if (cmd.acc_max && sts.rec_valid && rd_cnt_q > max_q) max_q <= rd_cnt_q;
		// restoring divide of count*10 by max, one quotient bit per cycle
		if (cmd.div_start) begin
			num_q <= {1'b0, rd_cnt_q, 3'b000} + {3'b000, rd_cnt_q, 1'b0};
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step && dstep_q != 6'd0) begin
			num_q <= {num_q[34:0], 1'b0};
			if (trial >= {4'd0, max_q}) begin
				rem_q <= trial - {4'd0, max_q};
				quo_q <= {quo_q[2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			ring_q <= '0;
			used_q <= '0;
			slot_q <= '0;
			rec_q <= '0;
			dstep_q <= '0;
			done <= 1'b0;
			status <= '0;
			next_call_slot <= '0;
			out_call_low <= '0;
			out_call_high <= '0;
			out_program_low <= '0;
			out_program_high <= '0;
			out_user_id <= '0;
			event_count <= '0;
			bar_ticks <= '0;
			for (int i = 0; i < NS; i++) begin
				vmask_q[i] <= '0;
				rpos_q[i] <= '0;
			end
		end else begin
			done <= cmd.fin;
			if (cmd.clear) begin
				armed_q <= 1'b1;
				ring_q <= '0;
				used_q <= '0;
				for (int i = 0; i < NS; i++) begin
					vmask_q[i] <= '0;
					rpos_q[i] <= '0;
				end
			end
			if (cmd.slot_rst) slot_q <= '0;
			else if (cmd.slot_inc) slot_q <= slot_q + SW'(1);
			else if (cmd.sel_slot) slot_q <= ssel_n;
			if (cmd.rec_rst) rec_q <= '0;
			else if (cmd.rec_inc) rec_q <= rec_q + RW'(1);
			if (cmd.claim) begin
				used_q[ring_q] <= 1'b1;
				vmask_q[ring_q] <= NR'(1);
				rpos_q[ring_q] <= RW'(1);
				ring_q <= ring_q + SW'(1);
			end else if (cmd.put_rec) begin
				vmask_q[slot_q][rpos_q[slot_q]] <= 1'b1;
				rpos_q[slot_q] <= rpos_q[slot_q] + RW'(1);
			end
			if (cmd.div_start) dstep_q <= 6'd36;
			else if (cmd.div_step && dstep_q != 6'd0) dstep_q <= dstep_q - 6'd1;
			if (cmd.fin) begin
				status <= cmd.st;
				next_call_slot <= cmd.claim ? 4'(ring_q + SW'(1)) :
					(cmd.clear ? 4'd0 : 4'(ring_q));
				if (cmd.st == kect_pkg::StReadOk) begin
					out_call_low <= sel_cl_q;
					out_call_high <= sel_ch_q;
					out_program_low <= sel_pl_q;
					out_program_high <= sel_ph_q;
					out_user_id <= sel_uid_q;
					event_count <= sel_cnt_q;
					bar_ticks <= (max_q == 32'd0) ? 4'd0 : quo_q;
				end else begin
					out_call_low <= '0;
					out_call_high <= '0;
					out_program_low <= '0;
					out_program_high <= '0;
					out_user_id <= '0;
					event_count <= '0;
					bar_ticks <= '0;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/keyed_event_counter_table_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_event_counter_table_unit: two-level keyed event counter table
// Counts events per call name and program/user record; clear and read.
//
//   channel | signals                          | handshake
//   input   | command, names, user_id, selects | start while busy low
//   result  | status, out_*, bar_ticks, ...    | done for one cycle
//
// Clear and ignored items finish straight after decode. A count event walks
// the slots, then the records of the matching slot. A read scans the slot's
// 32 counts and runs a 36-step bit-serial divide. Reset leaves the table disarmed.
// The result cannot be held off; busy stays high until it is shown.
// ----------------------------------------------------------------------------
`default_nettype none
module keyed_event_counter_table_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [63:0] call_name_low,
	input  wire logic [63:0] call_name_high,
	input  wire logic [63:0] program_name_low,
	input  wire logic [63:0] program_name_high,
	input  wire logic [31:0] user_id,
	input  wire logic [3:0]  slot_select,
	input  wire logic [4:0]  record_select,
	output logic             done,
	output logic [2:0]       status,
	output logic [63:0]      out_call_low,
	output logic [63:0]      out_call_high,
	output logic [63:0]      out_program_low,
	output logic [63:0]      out_program_high,
	output logic [31:0]      out_user_id,
	output logic [31:0]      event_count,
	output logic [3:0]       bar_ticks,
	output logic [3:0]       next_call_slot
);
	kect_pkg::kect_cmd_t cmd;
	kect_pkg::kect_sts_t sts;

	kect_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .sts(sts)
	);

	kect_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.command(command), .call_name_low(call_name_low),
		.call_name_high(call_name_high), .program_name_low(program_name_low),
		.program_name_high(program_name_high), .user_id(user_id),
		.slot_select(slot_select), .record_select(record_select),
		.done(done), .status(status), .out_call_low(out_call_low),
		.out_call_high(out_call_high), .out_program_low(out_program_low),
		.out_program_high(out_program_high), .out_user_id(out_user_id),
		.event_count(event_count), .bar_ticks(bar_ticks),
		.next_call_slot(next_call_slot)
	);
endmodule
`default_nettype wire
